/* rtl/core/rsn_pkg.sv */
// Package for the ring sequential normalizer: constants and types.
// No dependencies.
package rsn_pkg;
	localparam int MaxRings = 64;
	localparam int IdxW = $clog2(MaxRings);
	localparam int CntW = $clog2(MaxRings + 1);
	localparam int RingW = 24;
	localparam int CfgW = 23;
	localparam int SumW = 32;
	localparam int NormW = 33;
	localparam int QW = 40;
	localparam int CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] RegStop = 1'b0;
	localparam logic [CfgIdxW-1:0] RegThresh = 1'b1;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_NORM,
		BK_DIV,
		BK_EMIT
	} bk_state_t;

	// layer summary handed from front to back
	typedef struct packed {
		logic [CntW-1:0] count;
		logic [NormW-1:0] first_norm;
		logic seq_mode;
	} layer_t;
endpackage

/* rtl/core/rsn_ram.sv */
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
module rsn_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/core/rsn_front.sv */
// Front end: accepts rings, keeps sum/max/min, computes first norm on close.
// Depends on rsn_pkg.
module rsn_front (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic signed [rsn_pkg::RingW-1:0] ring,
	input logic mark,
	input logic [rsn_pkg::CfgW-1:0] stop_energy,
	input logic [rsn_pkg::CfgW-1:0] energy_threshold,
	output logic [rsn_pkg::IdxW-1:0] waddr,
	output logic close,
	output rsn_pkg::layer_t layer
);
	import rsn_pkg::*;
	logic [CntW-1:0] count_q;
	logic signed [SumW-1:0] sum_q;
	logic signed [RingW-1:0] max_q, min_q;
	logic signed [SumW-1:0] sum_n;
	logic signed [RingW-1:0] max_n, min_n;
	logic [SumW-1:0] abs_sum;
	logic [NormW-1:0] fn, absmin, mx;
	logic [CntW-1:0] cnt_n;

	assign waddr = count_q[IdxW-1:0];
	assign cnt_n = count_q + CntW'(1);
	assign sum_n = sum_q + SumW'(ring);
	assign max_n = (count_q == '0 || ring > max_q) ? ring : max_q;
	assign min_n = (count_q == '0 || ring < min_q) ? ring : min_q;
	assign close = take && (mark || cnt_n >= CntW'(MaxRings));
	assign abs_sum = sum_n[SumW-1] ? SumW'(-sum_n) : SumW'(sum_n);
	assign absmin = min_n[RingW-1] ? NormW'(-33'(min_n)) : NormW'(min_n);
	assign mx = max_n[RingW-1] ? '0 : NormW'(max_n);

	always_comb begin
		fn = NormW'(abs_sum);
		layer.seq_mode = 1'b1;
		if (fn < NormW'(stop_energy)) begin
			layer.seq_mode = 1'b0;
			// raise to max (then to |min| if larger) when max is non-negative and not below |sum|
			if (!max_n[RingW-1] && fn <= mx) begin
				fn = mx;
				if (fn < absmin) fn = absmin;
			end
			if (fn < NormW'(energy_threshold)) fn = NormW'(energy_threshold);
		end
		layer.first_norm = fn;
		layer.count = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
		end else if (take) begin
			count_q <= close ? '0 : cnt_n;
			sum_q <= close ? '0 : sum_n;
		end
	end
	always_ff @(posedge clk) begin
		if (take) begin
			max_q <= max_n;
			min_q <= min_n;
		end
	end
endmodule

/* rtl/core/rsn_back.sv */
// Back end: walks stored rings, tracks norms, divides, emits results.
// Depends on rsn_pkg.
module rsn_back (
	input logic clk,
	input logic arst_n,
	input logic go,
	input rsn_pkg::layer_t layer,
	input logic [rsn_pkg::CfgW-1:0] stop_energy,
	input logic [rsn_pkg::CfgW-1:0] energy_threshold,
	output logic [rsn_pkg::IdxW-1:0] raddr,
	input logic signed [rsn_pkg::RingW-1:0] rdata,
	output logic active,
	output logic strobe,
	output logic signed [rsn_pkg::QW-1:0] norm_value,
	output logic was_scaled,
	output logic last_of_layer
);
	import rsn_pkg::*;
	localparam int BitCntW = $clog2(QW + 1);
	bk_state_t state_q, state_n;
	layer_t lay_q;
	logic [CntW-1:0] idx_q;
	logic [NormW-1:0] norm_q;
	logic fb_q;
	logic signed [RingW-1:0] prev_q;
	logic [QW-1:0] quo_q;
	logic [NormW:0] rem_q;
	logic [BitCntW-1:0] bit_q;
	logic neg_q, scl_q;
	logic [NormW:0] rem_sh, rem_sub;
	logic signed [NormW+1:0] diff;
	logic [NormW-1:0] absd, nrm;
	logic div_done, last_ring;

	// fetch the next ring during the emit cycle so it is ready at the next norm cycle
	assign raddr = (state_q == BK_EMIT) ? IdxW'(idx_q + CntW'(1)) : idx_q[IdxW-1:0];
	assign active = (state_q != BK_IDLE);
	assign last_ring = (idx_q + CntW'(1) == lay_q.count);
	assign diff = $signed({2'b00, norm_q}) - (NormW+2)'(prev_q);
	assign absd = diff[NormW+1] ? NormW'(-diff) : NormW'(diff);

	// norm for the ring at idx_q
	always_comb begin
		nrm = norm_q;
		if (lay_q.seq_mode && idx_q != '0) begin
			nrm = absd;
			if (fb_q || absd < NormW'(stop_energy)) nrm = lay_q.first_norm;
		end
	end

	assign rem_sh = {rem_q[NormW-1:0], quo_q[QW-1]};
	assign rem_sub = rem_sh - {1'b0, norm_q};
	assign div_done = (bit_q == '0);

	always_comb begin
		unique case (state_q)
			BK_IDLE: state_n = go ? BK_NORM : BK_IDLE;
			BK_NORM: state_n = BK_DIV;
			BK_DIV: state_n = div_done ? BK_EMIT : BK_DIV;
			BK_EMIT: state_n = last_ring ? BK_IDLE : BK_NORM;
			default: state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		strobe = (state_q == BK_EMIT);
		was_scaled = scl_q;
		last_of_layer = last_ring;
		norm_value = neg_q ? QW'(-quo_q) : QW'(quo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_n;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				lay_q <= layer;
				idx_q <= '0;
				fb_q <= 1'b0;
				norm_q <= layer.first_norm;
			end
			BK_NORM: begin
				// rdata holds ring idx_q; load the divider
				if (lay_q.seq_mode && idx_q != '0 &&
					(fb_q || absd < NormW'(stop_energy))) fb_q <= 1'b1;
				norm_q <= nrm;
				neg_q <= rdata[RingW-1];
				quo_q <= QW'({rdata[RingW-1] ? 24'(-rdata) : 24'(rdata), 16'h0000});
				rem_q <= '0;
				scl_q <= (nrm != NormW'(energy_threshold)) && (nrm != '0);
				bit_q <= BitCntW'(QW);
				prev_q <= rdata;
			end
			BK_DIV: begin
				// one restoring step per cycle; skipped when raw
				if (!div_done) begin
					bit_q <= bit_q - BitCntW'(1);
					if (scl_q) begin
						if (!rem_sub[NormW]) begin
							rem_q <= rem_sub;
							quo_q <= {quo_q[QW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[QW-2:0], 1'b0};
						end
					end
				end
			end
			BK_EMIT: idx_q <= idx_q + CntW'(1);
			default: ;
		endcase
	end
endmodule

/* rtl/core/ring_sequential_normalizer.sv */
// Top level of the ring sequential normalizer.
// Depends on rsn_pkg, rsn_front, rsn_back, rsn_ram.
//
// Accepts one ring per cycle while not busy; a marked ring (or the 64th)
// closes the layer and hands its summary to the back end, which raises busy
// until every result of the layer is out. Each result passes through a RAM
// read/norm state, the bit-serial restoring divider and an emit state.
// Results come one per strobe and cannot be stalled.
module ring_sequential_normalizer (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [rsn_pkg::RingW-1:0] ring_energy,
	input logic end_of_layer,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [rsn_pkg::CfgIdxW-1:0] cfg_index,
	input logic [31:0] cfg_data,
	output logic strobe,
	output logic signed [rsn_pkg::QW-1:0] norm_value,
	output logic was_scaled,
	output logic last_of_layer
);
	import rsn_pkg::*;
	logic [CfgW-1:0] stop_q, thresh_q;
	logic take, close, go_q, active;
	logic [IdxW-1:0] waddr, raddr;
	logic signed [RingW-1:0] rdata;
	layer_t layer, layer_q;

	assign cfg_ready = 1'b1;
	assign take = start && !busy;
	assign busy = go_q || active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= CfgW'(100);
			thresh_q <= CfgW'(1);
			go_q <= 1'b0;
		end else begin
			go_q <= close;
			if (cfg_valid) begin
				unique case (cfg_index)
					RegStop: stop_q <= cfg_data[CfgW-1:0];
					RegThresh: thresh_q <= cfg_data[CfgW-1:0];
					default: ;
				endcase
			end
		end
	end
	// register the summary so the last ring lands in RAM first
	always_ff @(posedge clk) if (close) layer_q <= layer;

	rsn_front u_front (
		.clk, .arst_n, .take, .ring(ring_energy), .mark(end_of_layer),
		.stop_energy(stop_q), .energy_threshold(thresh_q),
		.waddr, .close, .layer
	);

	rsn_ram #(.Width(RingW), .Depth(MaxRings)) u_ram (
		.clk, .we(take), .waddr, .wdata(ring_energy), .raddr, .rdata
	);

	rsn_back u_back (
		.clk, .arst_n, .go(go_q), .layer(layer_q),
		.stop_energy(stop_q), .energy_threshold(thresh_q),
		.raddr, .rdata, .active, .strobe, .norm_value, .was_scaled,
		.last_of_layer
	);
endmodule
